// ----- src/bfua_pkg.sv -----
// ----------------------------------------------------------------------------
// bfua_pkg
// Shared types and codes for the best-fit unit allocator: request and
// response words, opcode and status codes, and the controller states.
// ----------------------------------------------------------------------------
package bfua_pkg;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_NOT_HELD  = 2'd3;

	localparam int SIZE_W  = 11;
	localparam int START_W = 10;
	localparam int OID_W   = 8;

	typedef struct packed {
		logic               opcode;
		logic [OID_W-1:0]   owner_id;
		logic [SIZE_W-1:0]  request_size;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] block_start;
	} out_word_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_FILL,
		S_RESP
	} state_t;

endpackage

// ----- src/bfua_ram.sv -----
// ----------------------------------------------------------------------------
// bfua_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bfua_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/best_fit_unit_allocator_unit.sv -----
// A release scans the map and then responds; an allocate scans the map, picks
// the best run, then marks the granted units one by one before it responds.
// Throughput: one request at a time, set by the single sequential pass of the
// map RAM read port over all UNITS entries, one entry per cycle.
// Reset: a clearing pass over every entry frees every unit; in_ready stays low
// until it completes.
// ----------------------------------------------------------------------------
// best_fit_unit_allocator_unit
// Best-fit allocator over a RAM-held ownership map. Each entry holds a used
// bit and an owner id. Requests scan the map once, then allocates mark units.
// ----------------------------------------------------------------------------
module best_fit_unit_allocator_unit
	import bfua_pkg::*;
#(
	parameter int UNITS      = 1024,
	parameter int OWNER_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int ADDR_W = $clog2(UNITS);
	localparam int LEN_W  = $clog2(UNITS + 1);
	localparam int ENT_W  = OWNER_BITS + 1;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(UNITS - 1);

	state_t state_q, state_d;

	logic                  op_q;
	logic [OWNER_BITS-1:0] who_q;
	logic [SIZE_W-1:0]     size_q;

	logic [ADDR_W-1:0] rd_idx_q;
	logic              issue_done_q;
	logic              rd_valid_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic [LEN_W-1:0]  run_len_q;
	logic [ADDR_W-1:0] run_start_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [ADDR_W-1:0] best_start_q;
	logic              found_q;
	logic              any_q;

	logic [ADDR_W-1:0] wr_idx_q;
	logic [SIZE_W-1:0] fill_cnt_q;

	logic      out_valid_q;
	out_word_t out_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ENT_W-1:0]  ram_rdata;

	logic              accept;
	logic              scan_last;
	logic              ent_used;
	logic              owner_hit;
	logic              cand_en;
	logic [LEN_W-1:0]  cand_len;
	logic [ADDR_W-1:0] cand_start;
	logic              cand_fit;
	logic              out_load;
	logic [31:0]       oid_ext;
	logic [31:0]       start_ext;

	bfua_ram #(
		.WIDTH(ENT_W),
		.DEPTH(UNITS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign accept    = in_valid && in_ready;
	assign scan_last = rd_valid_s1 && (idx_s1 == LAST);
	assign ent_used  = ram_rdata[OWNER_BITS];
	assign owner_hit = ent_used && (ram_rdata[OWNER_BITS-1:0] == who_q);
	assign oid_ext   = 32'(in_word.owner_id);
	assign start_ext = 32'(best_start_q);
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// Close a run on a used entry, or on the last entry while still free.
	always_comb begin
		cand_en    = 1'b0;
		cand_len   = run_len_q;
		cand_start = run_start_q;
		if (rd_valid_s1) begin
			if (ent_used) begin
				cand_en = (run_len_q != '0);
			end else if (idx_s1 == LAST) begin
				cand_en  = 1'b1;
				cand_len = run_len_q + LEN_W'(1);
				if (run_len_q == '0) begin
					cand_start = idx_s1;
				end
			end
		end
	end

	assign cand_fit = cand_en && (op_q == OP_ALLOC) &&
		(32'(cand_len) >= 32'(size_q)) && (!found_q || (cand_len < best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rd_idx_q;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (rd_idx_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// release frees matching entries right behind the read
				ram_we    = rd_valid_s1 && (op_q == OP_RELEASE) && owner_hit;
				ram_waddr = idx_s1;
				if (scan_last) begin
					state_d = (op_q == OP_ALLOC) ? S_FINISH : S_RESP;
				end
			end
			S_FINISH: begin
				state_d = (found_q && (size_q != '0)) ? S_FILL : S_RESP;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = wr_idx_q;
				ram_wdata = {1'b1, who_q};
				if (fill_cnt_q == SIZE_W'(1)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN) && !issue_done_q;
			if (state_q == S_CLEAR) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end else if (accept) begin
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
			end else if ((state_q == S_SCAN) && !issue_done_q) begin
				if (rd_idx_q == LAST) begin
					issue_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + ADDR_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			op_q      <= in_word.opcode;
			who_q     <= oid_ext[OWNER_BITS-1:0];
			size_q    <= in_word.request_size;
			run_len_q <= '0;
			found_q   <= 1'b0;
			any_q     <= 1'b0;
		end
		if ((state_q == S_SCAN) && rd_valid_s1) begin
			if (ent_used) begin
				run_len_q <= '0;
			end else begin
				run_len_q <= run_len_q + LEN_W'(1);
				if (run_len_q == '0) begin
					run_start_q <= idx_s1;
				end
			end
			if (cand_fit) begin
				best_len_q   <= cand_len;
				best_start_q <= cand_start;
				found_q      <= 1'b1;
			end
			if (owner_hit) begin
				any_q <= 1'b1;
			end
		end
		if (state_q == S_FINISH) begin
			wr_idx_q   <= best_start_q;
			fill_cnt_q <= size_q;
		end else if (state_q == S_FILL) begin
			wr_idx_q   <= wr_idx_q + ADDR_W'(1);
			fill_cnt_q <= fill_cnt_q - SIZE_W'(1);
		end
		if (out_load) begin
			if (op_q == OP_ALLOC) begin
				out_q.status      <= found_q ? ST_ALLOCATED : ST_NO_FIT;
				out_q.block_start <= found_q ? start_ext[START_W-1:0] : '0;
			end else begin
				out_q.status      <= any_q ? ST_RELEASED : ST_NOT_HELD;
				out_q.block_start <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.status != ST_ALLOCATED)) |-> (out_word.block_start == '0))
		else $error("block_start nonzero without a grant");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (fill_cnt_q != '0))
		else $error("fill running with zero count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second word taken while busy");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN))
		else $error("map read data arrived outside scan");

	a_scan_frees_only: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == S_SCAN)) |-> ((ram_wdata == '0) && (op_q == OP_RELEASE)))
		else $error("scan wrote something other than a release");

endmodule

// ----- tb/sv/best_fit_unit_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// best_fit_unit_allocator_unit_tb
// Self-checking bench for the best-fit allocator. A queue of request words,
// directed corner cases first and then random owner traffic, feeds a clocked
// driver. Each accepted word runs through a local copy of the unit map to
// predict its response. A clocked monitor compares every response word with
// the oldest prediction. Both sides stall at random.
// ----------------------------------------------------------------------------
module best_fit_unit_allocator_unit_tb;
	import bfua_pkg::*;

	localparam int N_UNITS      = 1024;
	localparam int N_OWNER_BITS = 8;
	localparam int N_RANDOM     = 556;
	localparam int LIMIT_CYCLES = 12_000_000;
	localparam int TAIL_CYCLES  = 3200;
	localparam int HOLD_AT      = 250;
	localparam int HOLD_CYCLES  = 6000;

	typedef struct {
		in_word_t    word;
		int unsigned gap;
		bit          drain;
	} req_item_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// local copy of the ownership map
	bit                    map_used [N_UNITS];
	logic [OID_W-1:0]      map_owner [N_UNITS];

	req_item_t   req_q[$];
	out_word_t   resp_due_q[$];
	int unsigned n_accepted = 0;
	int unsigned n_checked  = 0;
	int unsigned n_errors   = 0;
	int unsigned n_cycles   = 0;
	int unsigned n_grant    = 0;
	int unsigned n_no_fit   = 0;
	int unsigned n_freed    = 0;
	int unsigned n_not_held = 0;
	int unsigned gap_cnt    = 0;
	int unsigned stall_cnt  = 0;
	bit          hold_done  = 1'b0;

	best_fit_unit_allocator_unit #(
		.UNITS      (N_UNITS),
		.OWNER_BITS (N_OWNER_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the map copy and return the response word it earns.
	function automatic out_word_t grant_response(input in_word_t w);
		out_word_t resp;
		int        u;
		int        run_start;
		int        run_len;
		int        best_start;
		int        best_len;
		bit        found;
		bit        any;
		resp = '0;
		if (w.opcode == OP_ALLOC) begin
			best_start = 0;
			best_len   = N_UNITS + 1;
			found      = 1'b0;
			u          = 0;
			while (u < N_UNITS) begin
				if (map_used[u]) begin
					u++;
				end else begin
					run_start = u;
					run_len   = 0;
					while (u < N_UNITS && !map_used[u]) begin
						run_len++;
						u++;
					end
					// strict compare keeps the earliest run on a tie
					if (run_len >= int'(w.request_size) && run_len < best_len) begin
						best_len   = run_len;
						best_start = run_start;
						found      = 1'b1;
					end
				end
			end
			if (found) begin
				for (u = best_start; u < best_start + int'(w.request_size); u++) begin
					if (u < N_UNITS) begin
						map_used[u]  = 1'b1;
						map_owner[u] = w.owner_id;
					end
				end
				resp.status      = ST_ALLOCATED;
				resp.block_start = best_start[START_W-1:0];
			end else begin
				resp.status = ST_NO_FIT;
			end
		end else begin
			any = 1'b0;
			for (u = 0; u < N_UNITS; u++) begin
				if (map_used[u] && map_owner[u] == w.owner_id) begin
					map_used[u] = 1'b0;
					any         = 1'b1;
				end
			end
			resp.status = any ? ST_RELEASED : ST_NOT_HELD;
		end
		return resp;
	endfunction

	// Mostly short gaps, a few long enough to land while the block sits idle.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 30);
		else
			return $urandom_range(50, 2500);
	endfunction

	task automatic add_req(input logic op, input logic [OID_W-1:0] owner,
			input logic [SIZE_W-1:0] size, input bit drain);
		req_item_t item;
		item.word.opcode       = op;
		item.word.owner_id     = owner;
		item.word.request_size = size;
		// back-to-back stretch with no sender gaps
		item.gap   = (req_q.size() >= 300 && req_q.size() < 360) ? 0 : pick_gap();
		item.drain = drain;
		req_q.push_back(item);
	endtask

	// Driver: predict on accept, then offer the next word after its gap.
	always @(posedge clk or negedge arst_n) begin : drive
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word  <= '0;
			gap_cnt = 0;
		end else begin
			if (in_valid && in_ready) begin
				resp_due_q.push_back(grant_response(in_word));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				next_valid = 1'b0;
				if (req_q.size() != 0) begin
					if (gap_cnt < req_q[0].gap) begin
						gap_cnt++;
					end else if (!(req_q[0].drain && resp_due_q.size() != 0)) begin
						in_word <= req_q[0].word;
						next_valid = 1'b1;
						void'(req_q.pop_front());
						gap_cnt = 0;
					end
				end
				in_valid <= next_valid;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a window with none.
	always @(posedge clk or negedge arst_n) begin : recv
		int unsigned r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (!hold_done && n_accepted >= HOLD_AT) begin
				stall_cnt = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall_cnt != 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!(n_checked >= 400 && n_checked < 460)) begin
					r = $urandom_range(0, 999);
					if (r < 100)
						stall_cnt = $urandom_range(1, 3);
					else if (r < 130)
						stall_cnt = $urandom_range(4, 40);
					else if (r == 130)
						stall_cnt = $urandom_range(100, 600);
				end
			end
		end
	end

	// Monitor: compare each response word with the oldest prediction.
	always @(posedge clk) begin : mon
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (resp_due_q.size() == 0) begin
				$error("unexpected response: status %0d block_start %0d",
					out_word.status, out_word.block_start);
				n_errors++;
			end else begin
				want = resp_due_q.pop_front();
				if (out_word.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_word.status);
					n_errors++;
				end
				if (out_word.block_start !== want.block_start) begin
					$error("block_start: expected %0d, actual %0d",
						want.block_start, out_word.block_start);
					n_errors++;
				end
				case (want.status)
					ST_ALLOCATED: n_grant++;
					ST_NO_FIT:    n_no_fit++;
					ST_RELEASED:  n_freed++;
					ST_NOT_HELD:  n_not_held++;
					default:      ;
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned           i;
		int unsigned           r;
		logic                  op;
		logic [OID_W-1:0]      owner;
		logic [SIZE_W-1:0]     size;

		// empty map, size zero, oversized, whole map, full map
		add_req(OP_RELEASE, 8'h00, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'h00, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'hFF, 11'h7FF, 1'b0);
		add_req(OP_ALLOC,   8'hFF, 11'd1025, 1'b0);
		add_req(OP_ALLOC,   8'hFF, 11'd1024, 1'b0);
		add_req(OP_ALLOC,   8'h55, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'hAA, 11'd1, 1'b0);
		add_req(OP_RELEASE, 8'hFF, 11'h7FF, 1'b0);
		// fragment the map, then exercise best fit, exact fit and a tie
		add_req(OP_ALLOC,   8'h01, 11'd100, 1'b0);
		add_req(OP_ALLOC,   8'h02, 11'd50, 1'b0);
		add_req(OP_ALLOC,   8'h03, 11'd200, 1'b0);
		add_req(OP_ALLOC,   8'h04, 11'd30, 1'b0);
		add_req(OP_ALLOC,   8'h05, 11'd644, 1'b0);
		add_req(OP_RELEASE, 8'h02, 11'd0, 1'b0);
		add_req(OP_RELEASE, 8'h04, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'h06, 11'd20, 1'b0);
		add_req(OP_RELEASE, 8'h05, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'h07, 11'd10, 1'b0);
		add_req(OP_ALLOC,   8'h08, 11'd40, 1'b0);
		add_req(OP_RELEASE, 8'h01, 11'd0, 1'b0);
		add_req(OP_ALLOC,   8'h09, 11'd554, 1'b0);
		add_req(OP_ALLOC,   8'h0A, 11'd60, 1'b0);
		// size zero marks nothing, so the release after it finds no units
		add_req(OP_ALLOC,   8'h5A, 11'd0, 1'b0);
		add_req(OP_RELEASE, 8'h5A, 11'd0, 1'b0);

		for (i = 0; i < N_RANDOM; i++) begin
			r     = $urandom_range(0, 99);
			owner = (r < 85) ? OID_W'($urandom_range(0, 15)) : OID_W'($urandom_range(0, 255));
			r     = $urandom_range(0, 99);
			if (r < 58) begin
				op = OP_ALLOC;
				r  = $urandom_range(0, 99);
				if (r < 5)
					size = '0;
				else if (r < 75)
					size = SIZE_W'($urandom_range(1, 32));
				else if (r < 90)
					size = SIZE_W'($urandom_range(33, 256));
				else if (r < 97)
					size = SIZE_W'($urandom_range(257, 1024));
				else
					size = SIZE_W'($urandom_range(1025, 2047));
			end else begin
				op   = OP_RELEASE;
				size = SIZE_W'($urandom_range(0, 2047));
			end
			// now and then hold the sender until every response is back
			add_req(op, owner, size, (i % 97) == 40);
		end

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || in_valid) @(posedge clk);
		while (resp_due_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d cycles, %0d responses checked.",
			n_accepted, n_cycles, n_checked);
		$display("Grants %0d, no fit %0d, releases %0d, releases of idle owners %0d.",
			n_grant, n_no_fit, n_freed, n_not_held);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
